[src/cll_pkg.sv]
// Shared types, constants and helpers for the cursor linked list engine.
`timescale 1ns / 1ps
`default_nettype none
package cll_pkg;
   localparam int NODES = 64;
   localparam int IDX_W = $clog2(NODES);
   localparam int POS_W = 6;
   localparam int VAL_W = 32;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [POS_W-1:0] pos_type;

   localparam idx_type FREE_HEAD = '0;
   localparam idx_type LIST_HEAD = IDX_W'(NODES - 1);

   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_DELETE = 2'd1;
   localparam logic [1:0] KIND_DUMP   = 2'd2;

   typedef struct packed {
      logic [1:0]              kind;
      pos_type                 position;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                    ok;
      logic                    has_value;
      logic signed [VAL_W-1:0] element_value;
      pos_type                 element_count;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
      idx_type data;
   } link_wr_type;

   typedef struct packed {
      logic             en;
      idx_type          addr;
      logic [VAL_W-1:0] data;
   } val_wr_type;

   // link value of an entry that was never written
   function automatic idx_type link_reset(input idx_type idx);
      if (idx == LIST_HEAD) begin
         return FREE_HEAD;
      end
      return idx + idx_type'(1);
   endfunction
endpackage
`default_nettype wire

[src/cll_link_store.sv]
// Link store: one write and one registered read port, per-entry valid bits.
`timescale 1ns / 1ps
`default_nettype none
module cll_link_store (
   input  logic                 clock,
   input  logic                 reset,
   input  cll_pkg::idx_type     rd_addr,
   input  cll_pkg::link_wr_type wr,
   output cll_pkg::idx_type     rd_data
);
   import cll_pkg::*;

   idx_type          mem_ff [NODES];
   logic [NODES-1:0] valid_ff;
   idx_type          mem_q_ff;
   idx_type          addr_q_ff;
   logic             valid_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      mem_q_ff   <= mem_ff[rd_addr];
      valid_q_ff <= valid_ff[rd_addr];
      addr_q_ff  <= rd_addr;
   end

   assign rd_data = valid_q_ff ? mem_q_ff : link_reset(addr_q_ff);
endmodule
`default_nettype wire

[src/cll_value_store.sv]
// Value store: one write and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module cll_value_store (
   input  logic                      clock,
   input  cll_pkg::idx_type          rd_addr,
   input  cll_pkg::val_wr_type       wr,
   output logic [cll_pkg::VAL_W-1:0] rd_data
);
   import cll_pkg::*;

   logic [VAL_W-1:0] mem_ff [NODES];
   logic [VAL_W-1:0] data_q_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      data_q_ff <= mem_ff[rd_addr];
   end

   assign rd_data = data_q_ff;
endmodule
`default_nettype wire

[src/cursor_linked_list_engine_core.sv]
// Top level: sequencer walking the node stores for insert, delete and dump.
// Bad positions, an unused kind and an empty dump answer in the cycle after the transfer;
// a full-store insert answers after the free-head read in S_INS_FREE; insert and delete
// walk the list to the position; dump gives one value per cycle per element.
// busy stays high for the whole walk; each link step is one read of the link store.
// Synchronous reset restores the store links at once through valid bits.
`timescale 1ns / 1ps
`default_nettype none
module cursor_linked_list_engine_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cll_pkg::req_type req_payload,
   output logic             rsp_strobe,
   output cll_pkg::rsp_type rsp_payload
);
   import cll_pkg::*;

   localparam logic [3:0] S_IDLE       = 4'd0;
   localparam logic [3:0] S_INS_FREE   = 4'd1;
   localparam logic [3:0] S_INS_NEXT   = 4'd2;
   localparam logic [3:0] S_WALK       = 4'd3;
   localparam logic [3:0] S_INS_LINK   = 4'd4;
   localparam logic [3:0] S_DEL_J      = 4'd5;
   localparam logic [3:0] S_DEL_F      = 4'd6;
   localparam logic [3:0] S_DEL_H      = 4'd7;
   localparam logic [3:0] S_DUMP_FIRST = 4'd8;
   localparam logic [3:0] S_DUMP       = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       op_ff, op_in;
   pos_type          pos_ff, pos_in;
   logic [VAL_W-1:0] val_ff, val_in;
   idx_type          k_ff, k_in;
   idx_type          j_ff, j_in;
   pos_type          n_ff, n_in;
   pos_type          len_ff, len_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   idx_type          link_raddr;
   idx_type          link_rd;
   link_wr_type      link_wr;
   val_wr_type       val_wr;
   logic [VAL_W-1:0] val_rd;

   logic             walk_done;
   logic             accept;
   logic [POS_W:0]   ins_limit;

   cll_link_store u_links (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (link_raddr),
      .wr      (link_wr),
      .rd_data (link_rd)
   );

   cll_value_store u_values (
      .clock   (clock),
      .rd_addr (link_raddr),
      .wr      (val_wr),
      .rd_data (val_rd)
   );

   assign accept    = start && (state_ff == S_IDLE);
   assign walk_done = (n_ff == ((state_ff == S_DUMP) ? len_ff : pos_ff));
   assign ins_limit = {1'b0, len_ff} + (POS_W+1)'(1);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      len_in        = len_ff;
      link_raddr    = k_ff;
      link_wr       = '{en: 1'b0, addr: FREE_HEAD, data: FREE_HEAD};
      val_wr        = '{en: 1'b0, addr: j_ff, data: val_ff};
      rsp_strobe_in = 1'b0;
      rsp_in        = '{ok: 1'b0, has_value: 1'b0, element_value: '0,
                        element_count: len_ff, last: 1'b1};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in  = req_payload.kind;
               pos_in = req_payload.position;
               val_in = req_payload.value;
               k_in   = LIST_HEAD;
               n_in   = pos_type'(1);
               case (req_payload.kind)
                  KIND_INSERT: begin
                     if (req_payload.position == '0 ||
                         {1'b0, req_payload.position} > ins_limit) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        link_raddr = FREE_HEAD;
                        state_in   = S_INS_FREE;
                     end
                  end
                  KIND_DELETE: begin
                     if (req_payload.position == '0 || req_payload.position > len_ff) begin
                        rsp_strobe_in = 1'b1;
                     end else begin
                        link_raddr = LIST_HEAD;
                        state_in   = S_WALK;
                     end
                  end
                  KIND_DUMP: begin
                     if (len_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_in.ok     = 1'b1;
                     end else begin
                        link_raddr = LIST_HEAD;
                        state_in   = S_DUMP_FIRST;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_INS_FREE: begin
            if (link_rd == FREE_HEAD || link_rd == LIST_HEAD) begin
               rsp_strobe_in = 1'b1;
               state_in      = S_IDLE;
            end else begin
               j_in       = link_rd;
               link_raddr = link_rd;
               val_wr     = '{en: 1'b1, addr: link_rd, data: val_ff};
               state_in   = S_INS_NEXT;
            end
         end
         S_INS_NEXT: begin
            link_wr    = '{en: 1'b1, addr: FREE_HEAD, data: link_rd};
            link_raddr = LIST_HEAD;
            k_in       = LIST_HEAD;
            n_in       = pos_type'(1);
            state_in   = S_WALK;
         end
         S_WALK: begin
            if (walk_done) begin
               if (op_ff == KIND_INSERT) begin
                  link_wr  = '{en: 1'b1, addr: j_ff, data: link_rd};
                  state_in = S_INS_LINK;
               end else begin
                  j_in       = link_rd;
                  link_raddr = link_rd;
                  state_in   = S_DEL_J;
               end
            end else begin
               k_in       = link_rd;
               n_in       = n_ff + pos_type'(1);
               link_raddr = link_rd;
            end
         end
         S_INS_LINK: begin
            link_wr              = '{en: 1'b1, addr: k_ff, data: j_ff};
            len_in               = len_ff + pos_type'(1);
            rsp_strobe_in        = 1'b1;
            rsp_in.ok            = 1'b1;
            rsp_in.element_count = len_ff + pos_type'(1);
            state_in             = S_IDLE;
         end
         S_DEL_J: begin
            link_wr    = '{en: 1'b1, addr: k_ff, data: link_rd};
            link_raddr = FREE_HEAD;
            state_in   = S_DEL_F;
         end
         S_DEL_F: begin
            link_wr  = '{en: 1'b1, addr: j_ff, data: link_rd};
            state_in = S_DEL_H;
         end
         S_DEL_H: begin
            link_wr              = '{en: 1'b1, addr: FREE_HEAD, data: j_ff};
            len_in               = len_ff - pos_type'(1);
            rsp_strobe_in        = 1'b1;
            rsp_in.ok            = 1'b1;
            rsp_in.element_count = len_ff - pos_type'(1);
            state_in             = S_IDLE;
         end
         S_DUMP_FIRST: begin
            k_in       = link_rd;
            link_raddr = link_rd;
            n_in       = pos_type'(1);
            state_in   = S_DUMP;
         end
         S_DUMP: begin
            rsp_strobe_in        = 1'b1;
            rsp_in.ok            = 1'b1;
            rsp_in.has_value     = 1'b1;
            rsp_in.element_value = val_rd;
            rsp_in.last          = walk_done;
            if (walk_done) begin
               state_in = S_IDLE;
            end else begin
               k_in       = link_rd;
               link_raddr = link_rd;
               n_in       = n_ff + pos_type'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         len_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pos_ff <= pos_in;
      val_ff <= val_in;
      k_ff   <= k_in;
      j_ff   <= j_in;
      n_ff   <= n_in;
      rsp_ff <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;
endmodule
`default_nettype wire

[src/cll_checker.sv]
// Port-level checks for the cursor linked list engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cll_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input cll_pkg::rsp_type rsp_payload
);
   import cll_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !busy)
      else $error("busy after reset");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("transfer accepted with no work and no result");

   a_more_while_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.last) |-> busy)
      else $error("non-final result while idle");

   a_value_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_payload.has_value) |-> rsp_payload.ok)
      else $error("element value without ok");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_payload.has_value) |-> rsp_payload.last)
      else $error("status result not marked last");
endmodule

bind cursor_linked_list_engine_core cll_checker u_cll_checker (.*);
`default_nettype wire
